### rtl/lmx_pkg.sv
package lmx_pkg;

  // data and coefficient widths
  localparam int DW = 32;            // distribution / result width
  localparam int CW = 16;            // Q4.12 direction weight
  localparam int ND = 9;             // D2Q9 directions
  localparam int PW = DW + CW;       // one product
  localparam int SW = PW + 4;        // sum of nine products
  localparam int HW = DW + 4;        // exact height sum
  localparam int NW = SW + 4;        // |S| * 16
  localparam int QB = DW + 1;        // quotient bits kept
  localparam int STEPS = 3;          // divide steps per stage
  localparam int DIV_STAGES = QB / STEPS;

  localparam int CFG_W = 64;
  localparam int CFG_IW = 3;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_DX_0_3 = 3'd0;
  localparam logic [CFG_IW-1:0] REG_DX_4_7 = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DY_0_3 = 3'd2;
  localparam logic [CFG_IW-1:0] REG_DY_4_7 = 3'd3;
  localparam logic [CFG_IW-1:0] REG_DIR_8  = 3'd4;

  // one velocity axis in flight through the divider
  typedef struct packed {
    logic [HW-1:0] rem;   // partial remainder
    logic [QB-1:0] n;     // numerator bits in, quotient bits out
    logic          ovf;   // quotient beyond QB bits
    logic          neg;   // weighted sum negative
  } axis_t;

  // one request in the divider pipeline
  typedef struct packed {
    logic              valid;
    logic [HW-1:0]     h;
    logic [DW-1:0]     height;
    logic              fault;
    axis_t [1:0]       ax;
  } div_t;

endpackage

### rtl/lmx_moments.sv
module lmx_moments import lmx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [DW-1:0] cell_f [ND],
  input  logic signed [CW-1:0] wx [ND],
  input  logic signed [CW-1:0] wy [ND],
  output div_t                 out_req
);

  logic                 a_vld_r, b_vld_r;
  logic signed [PW-1:0] px_r [ND];
  logic signed [PW-1:0] py_r [ND];
  logic signed [PW-1:0] px_nxt [ND];
  logic signed [PW-1:0] py_nxt [ND];
  logic signed [HW-1:0] ha_r, ha_nxt, hb_r;
  logic signed [SW-1:0] sx_r, sy_r, sx_nxt, sy_nxt;
  div_t                 c_r, c_nxt;

  // stage A: products and height sum
  always_comb begin
    ha_nxt = '0;
    for (int d = 0; d < ND; d++) begin
      px_nxt[d] = cell_f[d] * wx[d];
      py_nxt[d] = cell_f[d] * wy[d];
      ha_nxt = ha_nxt + HW'(cell_f[d]);
    end
  end

  // stage B: weighted sums
  always_comb begin
    sx_nxt = '0;
    sy_nxt = '0;
    for (int d = 0; d < ND; d++) begin
      sx_nxt = sx_nxt + SW'(px_r[d]);
      sy_nxt = sy_nxt + SW'(py_r[d]);
    end
  end

  // stage C: magnitudes, divider seed, height saturation
  always_comb begin
    logic signed [SW-1:0] s;
    logic [SW-1:0]        mag;
    logic [NW-1:0]        num;
    c_nxt = '0;
    c_nxt.valid = b_vld_r;
    c_nxt.h = hb_r;
    c_nxt.fault = hb_r[HW-1] || (hb_r == '0);
    if (hb_r > HW'(signed'({1'b0, {(DW-1){1'b1}}})))
      c_nxt.height = {1'b0, {(DW-1){1'b1}}};
    else if (hb_r < -HW'(signed'({1'b0, {(DW-1){1'b1}}})) - HW'(1))
      c_nxt.height = {1'b1, {(DW-1){1'b0}}};
    else
      c_nxt.height = hb_r[DW-1:0];
    for (int a = 0; a < 2; a++) begin
      s = (a == 0) ? sx_r : sy_r;
      mag = s[SW-1] ? SW'(-s) : SW'(s);
      num = {mag, 4'b0000};
      c_nxt.ax[a].neg = s[SW-1];
      c_nxt.ax[a].rem = HW'(num[NW-1:QB]);
      c_nxt.ax[a].ovf = HW'(num[NW-1:QB]) >= hb_r;
      c_nxt.ax[a].n = num[QB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_r.valid <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_r <= c_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      ha_r <= ha_nxt;
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
      hb_r <= ha_r;
    end
  end

  assign out_req = c_r;

endmodule

### rtl/lmx_div_stage.sv
module lmx_div_stage import lmx_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  div_t d_in,
  output div_t d_out
);

  div_t q_r, q_nxt;

  // restoring divide, STEPS quotient bits per axis
  always_comb begin
    logic [HW:0]   t;
    logic [HW-1:0] rem;
    logic [QB-1:0] n;
    q_nxt = d_in;
    for (int a = 0; a < 2; a++) begin
      rem = d_in.ax[a].rem;
      n = d_in.ax[a].n;
      for (int s = 0; s < STEPS; s++) begin
        t = {rem, n[QB-1]};
        n = {n[QB-2:0], 1'b0};
        if (t >= {1'b0, d_in.h}) begin
          t = t - {1'b0, d_in.h};
          n[0] = 1'b1;
        end
        rem = t[HW-1:0];
      end
      q_nxt.ax[a].rem = rem;
      q_nxt.ax[a].n = n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (adv) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

### rtl/lbm_d2q9_moment_extraction.sv
// channel | ports                                   | direction
// input   | in_valid, in_stall, in_dist_0..8        | in
// output  | out_valid, out_stall, out_height, vel,  | out
//         | out_height_fault                        |
// config  | cfg_we, cfg_index, cfg_wdata            | in
//
// One request per cycle unless stalled; pipeline: products, sums, divider seed,
// 11 divider stages of 3 quotient bits each, output register.
// The whole pipeline advances unless the output holds a request under stall.
// rst_n clears the valid bits and the weight registers.
module lbm_d2q9_moment_extraction import lmx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IW-1:0]    cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [DW-1:0] in_dist_0,
  input  logic signed [DW-1:0] in_dist_1,
  input  logic signed [DW-1:0] in_dist_2,
  input  logic signed [DW-1:0] in_dist_3,
  input  logic signed [DW-1:0] in_dist_4,
  input  logic signed [DW-1:0] in_dist_5,
  input  logic signed [DW-1:0] in_dist_6,
  input  logic signed [DW-1:0] in_dist_7,
  input  logic signed [DW-1:0] in_dist_8,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DW-1:0] out_height,
  output logic signed [DW-1:0] out_vel_x,
  output logic signed [DW-1:0] out_vel_y,
  output logic                 out_height_fault
);

  logic [CFG_W-1:0] dx03_r, dx47_r, dy03_r, dy47_r;
  logic [31:0]      dir8_r;
  logic signed [CW-1:0] wx [ND];
  logic signed [CW-1:0] wy [ND];
  logic signed [DW-1:0] cell_f [ND];
  logic adv;
  div_t stg [DIV_STAGES+1];
  logic                 out_valid_r;
  logic signed [DW-1:0] height_r, vx_r, vy_r, vx_nxt, vy_nxt;
  logic                 fault_r;

  // weight registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx03_r <= '0;
      dx47_r <= '0;
      dy03_r <= '0;
      dy47_r <= '0;
      dir8_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DX_0_3: dx03_r <= cfg_wdata;
        REG_DX_4_7: dx47_r <= cfg_wdata;
        REG_DY_0_3: dy03_r <= cfg_wdata;
        REG_DY_4_7: dy47_r <= cfg_wdata;
        REG_DIR_8:  dir8_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // unpack weights
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      wx[k]   = dx03_r[k*CW +: CW];
      wx[k+4] = dx47_r[k*CW +: CW];
      wy[k]   = dy03_r[k*CW +: CW];
      wy[k+4] = dy47_r[k*CW +: CW];
    end
    wx[8] = dir8_r[CW-1:0];
    wy[8] = dir8_r[2*CW-1:CW];
  end

  assign cell_f[0] = in_dist_0;
  assign cell_f[1] = in_dist_1;
  assign cell_f[2] = in_dist_2;
  assign cell_f[3] = in_dist_3;
  assign cell_f[4] = in_dist_4;
  assign cell_f[5] = in_dist_5;
  assign cell_f[6] = in_dist_6;
  assign cell_f[7] = in_dist_7;
  assign cell_f[8] = in_dist_8;

  assign adv = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  lmx_moments u_mom (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid),
    .cell_f(cell_f), .wx(wx), .wy(wy), .out_req(stg[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    lmx_div_stage u_div (
      .clk(clk), .rst_n(rst_n), .adv(adv), .d_in(stg[g]), .d_out(stg[g+1])
    );
  end

  // saturate and sign the quotients
  always_comb begin
    logic [QB-1:0] q, lim;
    logic [DW-1:0] v;
    vx_nxt = '0;
    vy_nxt = '0;
    for (int a = 0; a < 2; a++) begin
      q = stg[DIV_STAGES].ax[a].n;
      lim = stg[DIV_STAGES].ax[a].neg ? QB'({1'b1, {(DW-1){1'b0}}})
                                      : QB'({1'b0, {(DW-1){1'b1}}});
      if (stg[DIV_STAGES].ax[a].ovf || q > lim)
        q = lim;
      v = stg[DIV_STAGES].ax[a].neg ? DW'(-q[DW-1:0]) : q[DW-1:0];
      if (stg[DIV_STAGES].fault)
        v = '0;
      if (a == 0)
        vx_nxt = v;
      else
        vy_nxt = v;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= stg[DIV_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      height_r <= stg[DIV_STAGES].height;
      fault_r <= stg[DIV_STAGES].fault;
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_height = height_r;
  assign out_vel_x = vx_r;
  assign out_vel_y = vy_r;
  assign out_height_fault = fault_r;

  // fault forces zero velocities
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_height_fault |-> out_vel_x == '0 && out_vel_y == '0)
    else $error("fault with nonzero velocity");

  // fault matches sign of height
  a_fault_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_height_fault == (out_height[DW-1] || out_height == '0))
    else $error("fault flag disagrees with height");

  // a stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vel_x) && $stable(out_height))
    else $error("stalled result changed");

endmodule
